### hw/rtl/ystc_pkg.sv
`timescale 1ns / 1ps

package ystc_pkg;

  localparam int HEAD_W           = 16;
  localparam int CNT_W            = 9;
  localparam int QUO_W            = 8;
  localparam int MAX_SEGMENTS_DEF = 256;

  localparam logic [HEAD_W-1:0] SEG_SIZE_RST = 16'd2048;
  localparam logic [HEAD_W-1:0] SEG_SIZE_MIN = 16'd256;
  localparam logic [CNT_W-1:0]  REQ_SEG_RST  = 9'd32;

  localparam logic REG_SEGMENT_SIZE      = 1'b0;
  localparam logic REG_REQUIRED_SEGMENTS = 1'b1;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

### hw/rtl/ystc_ram.sv
`timescale 1ns / 1ps

module ystc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/yaw_sweep_coverage_tracker.sv
`timescale 1ns / 1ps
// A sample walks ceil(|heading change| / segment size) segment steps, at most 128;
// each step is a read-modify-write of the segment map RAM, and the segment index comes from
// a bit-serial division, repeated when the walk wraps.
// A start clears the map RAM one entry per cycle before its result is issued.
// One transaction at a time; the next is accepted from the cycle after the previous result loads.
// Reset: synchronous, active low; a full map clear follows, with in_tready low.
module yaw_sweep_coverage_tracker import ystc_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] heading
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] sweep_done, [9:1] visited_count, [15:10] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int EW = (AW > QUO_W) ? AW : QUO_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_idx_r;
  logic                start_pend_r;
  logic [HEAD_W-1:0]   seg_r;
  logic [CNT_W-1:0]    req_r;
  logic [HEAD_W-1:0]   last_r;
  logic [CNT_W-1:0]    total_r;
  logic                done_r;
  logic [HEAD_W-1:0]   a_r;
  logic                neg_r;
  logic [HEAD_W-1:0]   mag_r;
  logic [HEAD_W:0]     off_r;
  logic [HEAD_W-1:0]   rem_r;
  logic [QUO_W-1:0]    q_r;
  logic [2:0]          dcnt_r;
  logic                chk_v_r;
  logic [AW-1:0]       chk_addr_r;
  logic                fwd_v_r;
  logic [AW-1:0]       fwd_addr_r;
  logic                out_tvalid_r;
  logic                out_done_r;
  logic [CNT_W-1:0]    out_count_r;

  logic [HEAD_W-1:0]   seg_eff;
  logic [HEAD_W-1:0]   diff;
  logic                neg_in;
  logic [HEAD_W-1:0]   mag_in;
  logic [HEAD_W:0]     step_sum;
  logic [HEAD_W:0]     off_next;
  logic                last_step;
  logic [EW-1:0]       q_ext;
  logic                q_ok;
  logic [7:0]          a_lo;
  logic [HEAD_W:0]     div_try;
  logic                div_ge;
  logic [0:0]          rd_data;
  logic                fwd_hit;
  logic                new_mark;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [0:0]          wr_data;
  logic [CNT_W-1:0]    total_nxt;

  assign seg_eff  = (seg_r < SEG_SIZE_MIN) ? SEG_SIZE_MIN : seg_r;
  assign diff     = in_tdata - last_r;
  assign neg_in   = (diff == 16'h8000) ? (in_tdata < last_r) : diff[HEAD_W-1];
  assign mag_in   = neg_in ? (~diff + 16'd1) : diff;

  assign step_sum  = neg_r ? ({1'b0, a_r} - {1'b0, seg_eff}) : ({1'b0, a_r} + {1'b0, seg_eff});
  assign off_next  = off_r + {1'b0, seg_eff};
  assign last_step = off_r >= {1'b0, mag_r};
  assign q_ext     = EW'(q_r);
  assign q_ok      = int'(q_r) < MAX_SEGMENTS;

  assign a_lo    = a_r[7:0];
  assign div_try = {rem_r, a_lo[dcnt_r]};
  assign div_ge  = div_try >= {1'b0, seg_eff};

  assign fwd_hit   = fwd_v_r && (fwd_addr_r == chk_addr_r);
  assign new_mark  = chk_v_r && !(rd_data[0] || fwd_hit);
  assign wr_en     = (state_r == S_CLEAR) || new_mark;
  assign wr_addr   = (state_r == S_CLEAR) ? clr_idx_r : chk_addr_r;
  assign wr_data   = (state_r == S_CLEAR) ? 1'b0 : 1'b1;
  assign total_nxt = (new_mark && (total_r != '1)) ? total_r + 9'd1 : total_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_count_r, out_done_r};

  ystc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SEGMENTS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (q_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      start_pend_r <= 1'b0;
      seg_r        <= SEG_SIZE_RST;
      req_r        <= REQ_SEG_RST;
      last_r       <= '0;
      total_r      <= '0;
      done_r       <= 1'b0;
      chk_v_r      <= 1'b0;
      fwd_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEGMENT_SIZE:      seg_r <= cfg_data;
          REG_REQUIRED_SEGMENTS: req_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      fwd_v_r    <= new_mark;
      fwd_addr_r <= chk_addr_r;
      chk_v_r    <= 1'b0;
      total_r    <= total_nxt;

      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == AW'(MAX_SEGMENTS - 1)) begin
            clr_idx_r <= '0;
            state_r   <= start_pend_r ? S_FIN : S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser == OP_START) begin
              last_r       <= in_tdata;
              total_r      <= '0;
              done_r       <= 1'b0;
              start_pend_r <= 1'b1;
              state_r      <= S_CLEAR;
            end else if (done_r) begin
              state_r <= S_FIN;
            end else begin
              last_r  <= in_tdata;
              a_r     <= last_r;
              neg_r   <= neg_in;
              mag_r   <= mag_in;
              off_r   <= '0;
              rem_r   <= {8'd0, last_r[15:8]};
              dcnt_r  <= 3'd7;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem_r <= HEAD_W'(div_try - {1'b0, seg_eff});
          end else begin
            rem_r <= div_try[HEAD_W-1:0];
          end
          q_r    <= {q_r[QUO_W-2:0], div_ge};
          dcnt_r <= dcnt_r - 3'd1;
          if (dcnt_r == 3'd0) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          chk_v_r    <= q_ok;
          chk_addr_r <= q_ext[AW-1:0];
          if (last_step) begin
            state_r <= S_DRAIN;
          end else begin
            off_r <= off_next;
            a_r   <= step_sum[HEAD_W-1:0];
            if (step_sum[HEAD_W]) begin
              rem_r   <= {8'd0, step_sum[15:8]};
              dcnt_r  <= 3'd7;
              state_r <= S_DIV;
            end else begin
              q_r <= neg_r ? (q_r - 1'b1) : (q_r + 1'b1);
            end
          end
        end
        S_DRAIN: begin
          done_r  <= total_nxt >= req_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_done_r   <= done_r;
            out_count_r  <= total_r;
            start_pend_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/ystc_checker.sv
`timescale 1ns / 1ps

module ystc_checker import ystc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          err_count,
  output int          outstanding
);

  localparam int HALF_TURN  = 32768;
  localparam int TURN_UNITS = 65536;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } sweep_status_t;

  logic [HEAD_W-1:0]           seg_size;
  logic [CNT_W-1:0]            req_segs;
  logic [MAX_SEGMENTS_DEF-1:0] seen_map;
  logic [CNT_W-1:0]            seen_total;
  logic [HEAD_W-1:0]           prev_heading;
  logic                        sweep_done;
  sweep_status_t               pending_status[$];

  function automatic void mark_slot(int unsigned idx);
    if (idx < MAX_SEGMENTS_DEF && !seen_map[idx]) begin
      seen_map[idx] = 1'b1;
      if (seen_total != '1) seen_total = seen_total + 1'b1;
    end
  endfunction

  function automatic void advance_sweep(logic op, logic [HEAD_W-1:0] hd);
    int unsigned seg;
    int unsigned mag;
    int unsigned steps;
    int unsigned off;
    int unsigned k;
    int diff;
    logic neg;
    logic [HEAD_W-1:0] ang;
    if (op == OP_START) begin
      seen_map     = '0;
      seen_total   = '0;
      sweep_done   = 1'b0;
      prev_heading = hd;
    end else if (!sweep_done) begin
      seg  = (seg_size < SEG_SIZE_MIN) ? SEG_SIZE_MIN : seg_size;
      diff = int'(hd) - int'(prev_heading);
      if (diff > HALF_TURN) diff = diff - TURN_UNITS;
      else if (diff < -HALF_TURN) diff = diff + TURN_UNITS;
      neg   = diff < 0;
      mag   = neg ? -diff : diff;
      steps = (mag + seg - 1) / seg;
      for (k = 0; k <= steps; k++) begin
        off = k * seg;
        ang = neg ? prev_heading - off[HEAD_W-1:0] : prev_heading + off[HEAD_W-1:0];
        mark_slot(ang / seg);
      end
      prev_heading = hd;
      if (seen_total >= req_segs) sweep_done = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sweep_status_t exp_st;
    if (!rst_n) begin
      seg_size     = SEG_SIZE_RST;
      req_segs     = REQ_SEG_RST;
      seen_map     = '0;
      seen_total   = '0;
      prev_heading = '0;
      sweep_done   = 1'b0;
      pending_status.delete();
      outstanding  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEGMENT_SIZE) seg_size = cfg_data;
        else req_segs = cfg_data[CNT_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (pending_status.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          exp_st = pending_status.pop_front();
          check_field("sweep_done", 16'(exp_st.done), 16'(out_tdata[0]));
          check_field("visited_count", 16'(exp_st.count), 16'(out_tdata[CNT_W:1]));
          check_field("padding", 16'd0, 16'(out_tdata[15:CNT_W+1]));
        end
      end
      if (in_tvalid && in_tready) begin
        advance_sweep(in_tuser, in_tdata);
        pending_status.push_back('{done: sweep_done, count: seen_total});
      end
      outstanding = pending_status.size();
    end
  end

endmodule

### bench/tb_yaw_sweep_coverage_tracker.sv
`timescale 1ns / 1ps

module tb_yaw_sweep_coverage_tracker;
  import ystc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_AT      = 300;
  localparam int LONG_HOLD    = 600;
  localparam int PHASE_ITEMS  = 125;
  localparam int NUM_PHASES   = 10;
  localparam int HALF_TURN    = 32768;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = OP_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = REG_SEGMENT_SIZE;
  logic [15:0] cfg_data   = '0;
  int          err_count;
  int          outstanding;

  int                cycle_count    = 0;
  int                sent_items     = 0;
  logic              quiet          = 1'b0;
  logic              long_hold_done = 1'b0;
  int unsigned       seg_now        = SEG_SIZE_RST;
  logic [HEAD_W-1:0] heading_now    = '0;

  logic [15:0]      seg_tab [0:NUM_PHASES-1] =
    '{16'd0, 16'd256, 16'd32768, 16'd32768, 16'd65535,
      16'd1000, 16'd300, 16'd100, 16'd5000, 16'd256};
  logic [CNT_W-1:0] req_tab [0:NUM_PHASES-1] =
    '{9'd0, 9'd256, 9'd2, 9'd1, 9'd511, 9'd40, 9'd100, 9'd256, 9'd7, 9'd1};

  yaw_sweep_coverage_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ystc_checker u_checker (.*);

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!long_hold_done && sent_items >= HOLD_AT) begin
        out_tready <= 1'b0;
        long_hold_done = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_tready <= 1'b1;
        repeat (40) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic op, input logic [HEAD_W-1:0] hd);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= hd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    heading_now = hd;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] seg, input logic [CNT_W-1:0] req);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SEGMENT_SIZE;
    cfg_data  <= seg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_REQUIRED_SEGMENTS;
    cfg_data  <= 16'(req);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_now = (seg < SEG_SIZE_MIN) ? SEG_SIZE_MIN : seg;
  endtask

  task automatic run_phase(input int n);
    int i;
    int run_left;
    int dir;
    int span;
    int r;
    logic [HEAD_W-1:0] hd;
    run_left = 0;
    dir      = 1;
    span     = (seg_now * 8 > HALF_TURN) ? HALF_TURN : seg_now * 8;
    for (i = 0; i < n; i++) begin
      if (run_left == 0 || $urandom_range(0, 99) == 0) begin
        r = $urandom_range(0, 9);
        hd = (r == 0) ? '0 : (r == 1) ? '1 : 16'($urandom);
        run_left = $urandom_range(4, 120);
        dir = $urandom_range(0, 1) ? 1 : -1;
        offer(OP_START, hd);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 9) == 0) dir = -dir;
          hd = heading_now + 16'(dir * int'($urandom_range(0, span)));
        end else if (r < 80) begin
          hd = heading_now + 16'(HALF_TURN);
        end else if (r < 85) begin
          hd = heading_now;
        end else if (r < 92) begin
          hd = heading_now + 16'(dir * int'($urandom_range(1, 3)));
        end else begin
          hd = 16'($urandom);
        end
        run_left--;
        offer(OP_SAMPLE, hd);
      end
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    offer(OP_SAMPLE, 16'd0);
    offer(OP_START, 16'd0);
    offer(OP_SAMPLE, 16'd0);
    offer(OP_SAMPLE, 16'd32768);
    offer(OP_SAMPLE, 16'd0);
    offer(OP_START, 16'd32768);
    offer(OP_SAMPLE, 16'd0);
    offer(OP_SAMPLE, 16'd65535);
    offer(OP_SAMPLE, 16'd1);
    offer(OP_SAMPLE, 16'd32769);
    offer(OP_SAMPLE, 16'd65535);
    offer(OP_SAMPLE, 16'd40000);
    offer(OP_START, 16'd12345);
    offer(OP_SAMPLE, 16'd20000);
    offer(OP_START, 16'd65535);
    offer(OP_SAMPLE, 16'd0);
    offer(OP_SAMPLE, 16'hAAAA);
    offer(OP_SAMPLE, 16'h5555);
    settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      set_regs(seg_tab[p], req_tab[p]);
      run_phase(PHASE_ITEMS);
      settle();
    end

    quiet = 1'b1;
    set_regs(SEG_SIZE_RST, REQ_SEG_RST);
    run_phase(150);
    settle();
    repeat (MAX_SEGMENTS_DEF + 20) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
